@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// clocked check, disabled while reset is low
`define ASSERT_CLK(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("assertion failed");
// clocked check that also runs during reset
`define ASSERT_CLK_NR(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk_s, rst_s, prop)
`define ASSERT_CLK_NR(lbl, clk_s, prop)
`endif
`endif

@@ rtl/dpef_pkg.sv @@
// types, constants, saturation helpers and the op sequence of the dipole pair unit
package dpef_pkg;

  // input beat
  typedef struct packed {
    logic signed [31:0] dip_i_x;
    logic signed [31:0] dip_i_y;
    logic signed [31:0] dip_i_z;
    logic signed [31:0] dip_j_x;
    logic signed [31:0] dip_j_y;
    logic signed [31:0] dip_j_z;
    logic signed [31:0] disp_x;
    logic signed [31:0] disp_y;
    logic signed [31:0] disp_z;
    logic               end_of_atom;
    logic               end_of_structure;
  } dpef_in_t;

  // result beat
  typedef struct packed {
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
    logic signed [47:0] atom_energy;
    logic signed [47:0] total_energy;
    logic               overflow;
  } dpef_out_t;

  // config register indexes
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_CUTOFF_SQ     = 1'b0;
  localparam cfg_idx_t CFG_COULOMB_SCALE = 1'b1;
  localparam logic [31:0] COULOMB_RESET  = 32'd65536;

  localparam logic signed [63:0] Q_THREE   = 64'sd3 <<< 32;
  localparam logic signed [63:0] Q_FIFTEEN = 64'sd15 <<< 32;
  localparam logic signed [63:0] S64_MAX   = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN   = {1'b1, {63{1'b0}}};
  localparam logic signed [47:0] S48_MAX   = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] S48_MIN   = {1'b1, {47{1'b0}}};
  localparam logic [63:0] INV_NUM          = 64'h0100_0000_0000_0000;

  // operand store slots
  typedef logic [4:0] slot_t;
  localparam slot_t S_MI0     = 5'd0;
  localparam slot_t S_MI1     = 5'd1;
  localparam slot_t S_MI2     = 5'd2;
  localparam slot_t S_MJ0     = 5'd3;
  localparam slot_t S_MJ1     = 5'd4;
  localparam slot_t S_MJ2     = 5'd5;
  localparam slot_t S_U0      = 5'd6;
  localparam slot_t S_U1      = 5'd7;
  localparam slot_t S_U2      = 5'd8;
  localparam slot_t S_INVR    = 5'd9;
  localparam slot_t S_KE      = 5'd10;
  localparam slot_t S_THREE   = 5'd11;
  localparam slot_t S_FIFTEEN = 5'd12;
  localparam slot_t S_DD      = 5'd13;
  localparam slot_t S_AU      = 5'd14;
  localparam slot_t S_BU      = 5'd15;
  localparam slot_t S_AUBU    = 5'd16;
  localparam slot_t S_IR2     = 5'd17;
  localparam slot_t S_IR3     = 5'd18;
  localparam slot_t S_IR4     = 5'd19;
  localparam slot_t S_T0      = 5'd20;
  localparam slot_t S_T1      = 5'd21;
  localparam int    NUM_SLOTS = 22;

  typedef enum logic [2:0] {
    OP_MUL, OP_ADD, OP_SUB, OP_ACCE, OP_ACC0, OP_ACC1, OP_ACC2
  } op_t;

  typedef struct packed {
    op_t   op;
    slot_t dst;
    slot_t src_a;
    slot_t src_b;
  } uop_t;

  typedef logic [5:0] pc_t;
  localparam pc_t PROG_LAST = 6'd59;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_CHK, ST_LOAD, ST_SQRT, ST_DIV_GO, ST_DIV_WAIT,
    ST_RD, ST_EX, ST_MW, ST_FIN
  } state_t;

  // value with saturation mark
  typedef struct packed {
    logic               hit;
    logic signed [63:0] val;
  } sval_t;

  typedef struct packed {
    logic               hit;
    logic signed [47:0] val;
  } sval48_t;

  // sign and magnitude back to two's complement, saturating
  function automatic sval_t signed_from(input logic neg, input logic [63:0] m);
    sval_t r;
    r.hit = 1'b0;
    if (!neg) begin
      if (m[63]) begin
        r.hit = 1'b1;
        r.val = S64_MAX;
      end else begin
        r.val = m;
      end
    end else begin
      if (m[63]) begin
        r.hit = |m[62:0];
        r.val = S64_MIN;
      end else begin
        r.val = -$signed(m);
      end
    end
    return r;
  endfunction

  function automatic sval_t sadd(input logic signed [63:0] a, input logic signed [63:0] b);
    sval_t r;
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    r.hit = s[64] != s[63];
    r.val = r.hit ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
    return r;
  endfunction

  function automatic sval_t ssub(input logic signed [63:0] a, input logic signed [63:0] b);
    sval_t r;
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    r.hit = s[64] != s[63];
    r.val = r.hit ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
    return r;
  endfunction

  // clamp pair term then add into a 48 bit accumulator
  function automatic sval48_t acc48(input logic signed [47:0] acc,
                                    input logic signed [63:0] x);
    sval48_t r;
    logic signed [47:0] xc;
    logic               xh;
    logic signed [48:0] s;
    xh = !((&x[63:47]) || !(|x[63:47]));
    xc = xh ? (x[63] ? S48_MIN : S48_MAX) : x[47:0];
    s  = {acc[47], acc} + {xc[47], xc};
    r.hit = xh || (s[48] != s[47]);
    r.val = (s[48] != s[47]) ? (s[48] ? S48_MIN : S48_MAX) : s[47:0];
    return r;
  endfunction

  function automatic uop_t mk(input op_t op, input slot_t d, input slot_t a, input slot_t b);
    uop_t u;
    u.op    = op;
    u.dst   = d;
    u.src_a = a;
    u.src_b = b;
    return u;
  endfunction

  // op sequence for one live pair
  function automatic uop_t prog_rom(input pc_t pc);
    uop_t       u;
    logic [1:0] k;
    pc_t        base;
    logic [3:0] st;
    slot_t      uk;
    slot_t      mik;
    slot_t      mjk;
    slot_t      acc_sel;
    if (pc >= 6'd48) begin
      k = 2'd2;
      base = 6'd48;
    end else if (pc >= 6'd36) begin
      k = 2'd1;
      base = 6'd36;
    end else begin
      k = 2'd0;
      base = 6'd24;
    end
    st  = 4'(pc - base);
    uk  = S_U0 + {3'b000, k};
    mik = S_MI0 + {3'b000, k};
    mjk = S_MJ0 + {3'b000, k};
    acc_sel = {3'b000, k};
    case (pc)
      6'd0:  u = mk(OP_MUL, S_T0, S_MI0, S_MJ0);
      6'd1:  u = mk(OP_MUL, S_T1, S_MI1, S_MJ1);
      6'd2:  u = mk(OP_ADD, S_DD, S_T0, S_T1);
      6'd3:  u = mk(OP_MUL, S_T0, S_MI2, S_MJ2);
      6'd4:  u = mk(OP_ADD, S_DD, S_DD, S_T0);
      6'd5:  u = mk(OP_MUL, S_T0, S_MI0, S_U0);
      6'd6:  u = mk(OP_MUL, S_T1, S_MI1, S_U1);
      6'd7:  u = mk(OP_ADD, S_AU, S_T0, S_T1);
      6'd8:  u = mk(OP_MUL, S_T0, S_MI2, S_U2);
      6'd9:  u = mk(OP_ADD, S_AU, S_AU, S_T0);
      6'd10: u = mk(OP_MUL, S_T0, S_MJ0, S_U0);
      6'd11: u = mk(OP_MUL, S_T1, S_MJ1, S_U1);
      6'd12: u = mk(OP_ADD, S_BU, S_T0, S_T1);
      6'd13: u = mk(OP_MUL, S_T0, S_MJ2, S_U2);
      6'd14: u = mk(OP_ADD, S_BU, S_BU, S_T0);
      6'd15: u = mk(OP_MUL, S_AUBU, S_AU, S_BU);
      6'd16: u = mk(OP_MUL, S_IR2, S_INVR, S_INVR);
      6'd17: u = mk(OP_MUL, S_IR3, S_IR2, S_INVR);
      6'd18: u = mk(OP_MUL, S_IR4, S_IR2, S_IR2);
      6'd19: u = mk(OP_MUL, S_T0, S_THREE, S_AUBU);
      6'd20: u = mk(OP_SUB, S_T0, S_DD, S_T0);
      6'd21: u = mk(OP_MUL, S_T0, S_T0, S_IR3);
      6'd22: u = mk(OP_MUL, S_T0, S_KE, S_T0);
      6'd23: u = mk(OP_ACCE, S_T0, S_T0, S_T0);
      default: begin
        // force component k
        case (st)
          4'd0:  u = mk(OP_MUL, S_T0, S_DD, uk);
          4'd1:  u = mk(OP_MUL, S_T1, mik, S_BU);
          4'd2:  u = mk(OP_ADD, S_T0, S_T0, S_T1);
          4'd3:  u = mk(OP_MUL, S_T1, mjk, S_AU);
          4'd4:  u = mk(OP_ADD, S_T0, S_T0, S_T1);
          4'd5:  u = mk(OP_MUL, S_T0, S_THREE, S_T0);
          4'd6:  u = mk(OP_MUL, S_T1, S_AUBU, uk);
          4'd7:  u = mk(OP_MUL, S_T1, S_FIFTEEN, S_T1);
          4'd8:  u = mk(OP_SUB, S_T0, S_T0, S_T1);
          4'd9:  u = mk(OP_MUL, S_T0, S_T0, S_IR4);
          4'd10: u = mk(OP_MUL, S_T0, S_KE, S_T0);
          4'd11: begin
            case (acc_sel)
              5'd0:    u = mk(OP_ACC0, S_T0, S_T0, S_T0);
              5'd1:    u = mk(OP_ACC1, S_T0, S_T0, S_T0);
              default: u = mk(OP_ACC2, S_T0, S_T0, S_T0);
            endcase
          end
          default: u = mk(OP_ADD, S_T0, S_T0, S_T0);
        endcase
      end
    endcase
    return u;
  endfunction

endpackage

@@ rtl/dpef_mul.sv @@
// iterative q32 multiplier: four 32x32 partial products, truncate, saturate
module dpef_mul
  import dpef_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic               done,
  output sval_t              res
);

  logic         busy_r;
  logic [2:0]   cnt_r;
  logic [63:0]  x_r;
  logic [63:0]  y_r;
  logic         neg_r;
  logic [63:0]  prod_r;
  logic [127:0] acc_r;
  logic         done_r;
  sval_t        res_r;

  logic [31:0]  xs;
  logic [31:0]  ys;
  logic [63:0]  pp;
  logic [127:0] addend;
  logic [127:0] acc_sum;
  sval_t        fin;

  // partial order: ll, lh, hl, hh
  assign xs = cnt_r[1] ? x_r[63:32] : x_r[31:0];
  assign ys = cnt_r[0] ? y_r[63:32] : y_r[31:0];
  assign pp = xs * ys;

  // previous partial aligned to its weight
  always_comb begin
    case (cnt_r)
      3'd1:    addend = {64'b0, prod_r};
      3'd2:    addend = {32'b0, prod_r, 32'b0};
      3'd3:    addend = {32'b0, prod_r, 32'b0};
      3'd4:    addend = {prod_r, 64'b0};
      default: addend = '0;
    endcase
  end

  assign acc_sum = acc_r + addend;

  // truncate to q32 and saturate
  always_comb begin
    if (|acc_sum[127:96]) begin
      fin.hit = 1'b1;
      fin.val = neg_r ? S64_MIN : S64_MAX;
    end else begin
      fin = signed_from(neg_r, acc_sum[95:32]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        x_r    <= a[63] ? 64'(-a) : 64'(a);
        y_r    <= b[63] ? 64'(-b) : 64'(b);
        neg_r  <= a[63] != b[63];
        acc_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r < 3'd4) begin
          prod_r <= pp;
        end
        if (cnt_r != 3'd0) begin
          acc_r <= acc_sum;
        end
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          res_r  <= fin;
        end
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

@@ rtl/dpef_div.sv @@
// restoring divider, 64 bit dividend by 32 bit divisor, one quotient bit per cycle
module dpef_div
  import dpef_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [63:0] quo
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] n_r;
  logic [63:0] q_r;
  logic [31:0] rem_r;
  logic [31:0] d_r;

  logic [32:0] sh;
  logic        ge;
  logic [32:0] diff;

  // shift in next dividend bit, trial subtract
  assign sh   = {rem_r, n_r[63]};
  assign ge   = sh >= {1'b0, d_r};
  assign diff = sh - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        n_r    <= num;
        d_r    <= den;
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? diff[31:0] : sh[31:0];
        n_r   <= {n_r[62:0], 1'b0};
        q_r   <= {q_r[62:0], ge};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

@@ rtl/dipole_pair_energy_force_unit.sv @@
// cutoff dipole-dipole pair energy and force accumulator, top level
//
//  channel | signals                        | direction | beat
//  in      | in_valid, in_stall, in_data    | in        | one neighbor pair
//  out     | out_valid, out_stall, out_data | out       | one atom result
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in | one register write
//
// a pair inside the cutoff holds in_stall through the squaring of the three displacement
// components, a check, 9 store loads, a 32 step root, four divides on the shared divider,
// 40 q32 multiplies (each a read, an issue and five partial passes), 20 add/sub/accumulate
// ops and a result state. a pair outside the cutoff holds it for squaring, check and result.
// a finished atom result waits in the output register, and the next atom end holds
// until it is taken. reset clears all accumulators and the cutoff, and sets the scale to 65536.
`include "assert_macros.svh"
module dipole_pair_energy_force_unit
  import dpef_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  dpef_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output dpef_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_idx_t    cfg_index,
  input  logic [31:0] cfg_data
);

  state_t state_r, state_nxt;
  logic [31:0] cutoff_r;
  logic [31:0] scale_r;
  dpef_in_t    item_r, item_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [63:0] dr2_r, dr2_nxt;
  logic [63:0] sq_v_r, sq_v_nxt;
  logic [63:0] sq_res_r, sq_res_nxt;
  logic [63:0] sq_bit_r, sq_bit_nxt;
  pc_t         pc_r, pc_nxt;
  logic signed [47:0] energy_acc_r, energy_acc_nxt;
  logic signed [47:0] force_acc_r [3];
  logic signed [47:0] force_acc_nxt [3];
  logic signed [47:0] total_acc_r, total_acc_nxt;
  logic        sat_flag_r, sat_flag_nxt;
  logic        out_valid_r, out_valid_nxt;
  dpef_out_t   out_data_r, out_data_nxt;

  // operand store
  logic signed [63:0] rf_mem [NUM_SLOTS];
  logic signed [63:0] rd_a_r;
  logic signed [63:0] rd_b_r;
  logic               wr_en;
  slot_t              wr_addr;
  logic signed [63:0] wr_data;

  uop_t               uop;
  logic signed [31:0] dsel;
  logic               dneg;
  logic [31:0]        dmag;
  logic [63:0]        dsq;
  logic [63:0]        sq_t;
  logic               mul_start;
  logic               mul_done;
  sval_t              mul_res;
  logic               div_start;
  logic               div_done;
  logic [63:0]        div_num;
  logic [63:0]        div_quo;
  sval_t              alu_v;
  sval48_t            acc_v;
  sval48_t            tot_v;
  sval_t              u_v;
  logic signed [47:0] ae;

  assign uop = prog_rom(pc_r);

  // displacement component picked by step
  always_comb begin
    case (step_r[1:0])
      2'd0:    dsel = item_r.disp_x;
      2'd1:    dsel = item_r.disp_y;
      default: dsel = item_r.disp_z;
    endcase
  end
  assign dneg = dsel[31];
  assign dmag = dneg ? 32'(-dsel) : 32'(dsel);
  assign dsq  = dmag * dmag;
  assign sq_t = sq_res_r + sq_bit_r;
  assign div_num = (step_r == 5'd3) ? INV_NUM : {dmag, 32'b0};
  assign ae = energy_acc_r >>> 1;

  dpef_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (rd_a_r),
    .b     (rd_b_r),
    .done  (mul_done),
    .res   (mul_res)
  );

  dpef_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (sq_res_r[31:0]),
    .done  (div_done),
    .quo   (div_quo)
  );

  // config registers, always writable
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= '0;
      scale_r  <= COULOMB_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CUTOFF_SQ:     cutoff_r <= cfg_data;
        CFG_COULOMB_SCALE: scale_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand store write and registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rf_mem[wr_addr] <= wr_data;
    end
    rd_a_r <= rf_mem[uop.src_a];
    rd_b_r <= rf_mem[uop.src_b];
  end

  // sequencer: next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    step_nxt       = step_r;
    dr2_nxt        = dr2_r;
    sq_v_nxt       = sq_v_r;
    sq_res_nxt     = sq_res_r;
    sq_bit_nxt     = sq_bit_r;
    pc_nxt         = pc_r;
    energy_acc_nxt = energy_acc_r;
    force_acc_nxt  = force_acc_r;
    total_acc_nxt  = total_acc_r;
    sat_flag_nxt   = sat_flag_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && out_stall;
    wr_en          = 1'b0;
    wr_addr        = S_T0;
    wr_data        = '0;
    mul_start      = 1'b0;
    div_start      = 1'b0;
    alu_v          = '0;
    acc_v          = '0;
    tot_v          = '0;
    u_v            = signed_from(dneg, div_quo);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          step_nxt  = '0;
          dr2_nxt   = '0;
          state_nxt = ST_SQ;
        end
      end
      // squared distance, one component a cycle
      ST_SQ: begin
        dr2_nxt  = dr2_r + dsq;
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd2) begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        step_nxt = '0;
        if (dr2_r != '0 && dr2_r < {8'b0, cutoff_r, 24'b0}) begin
          state_nxt = ST_LOAD;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      // dipoles and constants into the store
      ST_LOAD: begin
        wr_en = 1'b1;
        case (step_r)
          5'd0: begin
            wr_addr = S_MI0;
            wr_data = {{24{item_r.dip_i_x[31]}}, item_r.dip_i_x, 8'b0};
          end
          5'd1: begin
            wr_addr = S_MI1;
            wr_data = {{24{item_r.dip_i_y[31]}}, item_r.dip_i_y, 8'b0};
          end
          5'd2: begin
            wr_addr = S_MI2;
            wr_data = {{24{item_r.dip_i_z[31]}}, item_r.dip_i_z, 8'b0};
          end
          5'd3: begin
            wr_addr = S_MJ0;
            wr_data = {{24{item_r.dip_j_x[31]}}, item_r.dip_j_x, 8'b0};
          end
          5'd4: begin
            wr_addr = S_MJ1;
            wr_data = {{24{item_r.dip_j_y[31]}}, item_r.dip_j_y, 8'b0};
          end
          5'd5: begin
            wr_addr = S_MJ2;
            wr_data = {{24{item_r.dip_j_z[31]}}, item_r.dip_j_z, 8'b0};
          end
          5'd6: begin
            wr_addr = S_KE;
            wr_data = {16'b0, scale_r, 16'b0};
          end
          5'd7: begin
            wr_addr = S_THREE;
            wr_data = Q_THREE;
          end
          default: begin
            wr_addr = S_FIFTEEN;
            wr_data = Q_FIFTEEN;
          end
        endcase
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd8) begin
          step_nxt   = '0;
          sq_v_nxt   = dr2_r;
          sq_res_nxt = '0;
          sq_bit_nxt = 64'h4000_0000_0000_0000;
          state_nxt  = ST_SQRT;
        end
      end
      // integer square root, one result bit a cycle
      ST_SQRT: begin
        if (sq_v_r >= sq_t) begin
          sq_v_nxt   = sq_v_r - sq_t;
          sq_res_nxt = (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_nxt = sq_res_r >> 1;
        end
        sq_bit_nxt = sq_bit_r >> 2;
        step_nxt   = step_r + 5'd1;
        if (step_r == 5'd31) begin
          step_nxt  = '0;
          state_nxt = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      // unit vector components, then 1/r
      ST_DIV_WAIT: begin
        if (div_done) begin
          wr_en = 1'b1;
          if (step_r == 5'd3) begin
            wr_addr   = S_INVR;
            wr_data   = div_quo;
            pc_nxt    = '0;
            state_nxt = ST_RD;
          end else begin
            wr_addr      = S_U0 + step_r;
            wr_data      = u_v.val;
            sat_flag_nxt = sat_flag_r | u_v.hit;
            state_nxt    = ST_DIV_GO;
          end
          step_nxt = step_r + 5'd1;
        end
      end
      ST_RD: begin
        state_nxt = ST_EX;
      end
      // one op of the pair sequence
      ST_EX: begin
        if (uop.op == OP_MUL) begin
          mul_start = 1'b1;
          state_nxt = ST_MW;
        end else begin
          case (uop.op)
            OP_ADD: begin
              alu_v = sadd(rd_a_r, rd_b_r);
              wr_en = 1'b1;
            end
            OP_SUB: begin
              alu_v = ssub(rd_a_r, rd_b_r);
              wr_en = 1'b1;
            end
            OP_ACCE: begin
              acc_v = acc48(energy_acc_r, rd_a_r);
              energy_acc_nxt = acc_v.val;
            end
            OP_ACC0: begin
              acc_v = acc48(force_acc_r[0], rd_a_r);
              force_acc_nxt[0] = acc_v.val;
            end
            OP_ACC1: begin
              acc_v = acc48(force_acc_r[1], rd_a_r);
              force_acc_nxt[1] = acc_v.val;
            end
            OP_ACC2: begin
              acc_v = acc48(force_acc_r[2], rd_a_r);
              force_acc_nxt[2] = acc_v.val;
            end
            default: ;
          endcase
          wr_addr      = uop.dst;
          wr_data      = alu_v.val;
          sat_flag_nxt = sat_flag_r | alu_v.hit | acc_v.hit;
          pc_nxt       = pc_r + 6'd1;
          state_nxt    = (pc_r == PROG_LAST) ? ST_FIN : ST_RD;
        end
      end
      ST_MW: begin
        if (mul_done) begin
          wr_en        = 1'b1;
          wr_addr      = uop.dst;
          wr_data      = mul_res.val;
          sat_flag_nxt = sat_flag_r | mul_res.hit;
          pc_nxt       = pc_r + 6'd1;
          state_nxt    = (pc_r == PROG_LAST) ? ST_FIN : ST_RD;
        end
      end
      // atom result beat
      ST_FIN: begin
        if (item_r.end_of_atom || item_r.end_of_structure) begin
          if (!(out_valid_r && out_stall)) begin
            tot_v = acc48(total_acc_r, {{16{ae[47]}}, ae});
            out_data_nxt.force_x      = force_acc_r[0];
            out_data_nxt.force_y      = force_acc_r[1];
            out_data_nxt.force_z      = force_acc_r[2];
            out_data_nxt.atom_energy  = ae;
            out_data_nxt.total_energy = tot_v.val;
            out_data_nxt.overflow     = sat_flag_r | tot_v.hit;
            out_valid_nxt    = 1'b1;
            force_acc_nxt[0] = '0;
            force_acc_nxt[1] = '0;
            force_acc_nxt[2] = '0;
            energy_acc_nxt   = '0;
            sat_flag_nxt     = 1'b0;
            total_acc_nxt    = item_r.end_of_structure ? '0 : tot_v.val;
            state_nxt        = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and accumulator registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      step_r         <= '0;
      pc_r           <= '0;
      energy_acc_r   <= '0;
      force_acc_r[0] <= '0;
      force_acc_r[1] <= '0;
      force_acc_r[2] <= '0;
      total_acc_r    <= '0;
      sat_flag_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      pc_r         <= pc_nxt;
      energy_acc_r <= energy_acc_nxt;
      force_acc_r  <= force_acc_nxt;
      total_acc_r  <= total_acc_nxt;
      sat_flag_r   <= sat_flag_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    dr2_r      <= dr2_nxt;
    sq_v_r     <= sq_v_nxt;
    sq_res_r   <= sq_res_nxt;
    sq_bit_r   <= sq_bit_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_CLK(a_mul_done_in_wait, clk, rst_n, mul_done |-> state_r == ST_MW)
  `ASSERT_CLK(a_div_done_in_wait, clk, rst_n, div_done |-> state_r == ST_DIV_WAIT)
  `ASSERT_CLK(a_root_nonzero, clk, rst_n, (state_r == ST_DIV_GO) |-> (sq_res_r != '0))
  `ASSERT_CLK_NR(a_reset_idle, clk, !rst_n |=> (state_r == ST_IDLE && !out_valid_r))

endmodule
